@@ rtl/pcfr_pkg.sv @@
// Shared types and constants for the PWM code frame receiver.
// No dependencies; every file of the block but pcfr_if imports this package.
`default_nettype none

package pcfr_pkg;

   localparam int FRAME_BITS      = 66;
   localparam int BIT_COUNT_WIDTH = 7;
   localparam int CSR_ADDR_WIDTH  = 5;

   typedef enum logic [2:0] {
      REG_SHORT_MIN       = 3'd0,
      REG_PREAMBLE_MAX    = 3'd1,
      REG_HEADER_MIN      = 3'd2,
      REG_HEADER_MAX      = 3'd3,
      REG_BIT_MAX         = 3'd4,
      REG_BIT_SPLIT       = 3'd5,
      REG_PREAMBLE_NEEDED = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [15:0] short_min_us;
      logic [15:0] preamble_max_us;
      logic [15:0] header_min_us;
      logic [15:0] header_max_us;
      logic [15:0] bit_max_us;
      logic [15:0] bit_split_us;
      logic [4:0]  preamble_needed;
   } cfg_type;

   typedef struct packed {
      logic        frame_done;
      logic        repeat_flag;
      logic        battery_low;
      logic [3:0]  buttons;
      logic [27:0] serial_number;
      logic [31:0] hopping_code;
      logic [63:0] raw_code;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/pcfr_if.sv @@
// Valid/ready channel interfaces for edge words and frame result words.
// No dependencies.
`default_nettype none

interface pcfr_req_if;
   logic        valid;
   logic        ready;
   logic        edge_level;
   logic [31:0] edge_time_us;

   modport source (output valid, output edge_level, output edge_time_us, input ready);
   modport sink   (input valid, input edge_level, input edge_time_us, output ready);
endinterface

interface pcfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_done;
   logic        repeat_flag;
   logic        battery_low;
   logic [3:0]  buttons;
   logic [27:0] serial_number;
   logic [31:0] hopping_code;
   logic [63:0] raw_code;

   modport source (output valid, output frame_done, output repeat_flag, output battery_low,
                   output buttons, output serial_number, output hopping_code,
                   output raw_code, input ready);
   modport sink   (input valid, input frame_done, input repeat_flag, input battery_low,
                   input buttons, input serial_number, input hopping_code,
                   input raw_code, output ready);
endinterface

`default_nettype wire

@@ rtl/pwm_code_frame_receiver_core.sv @@
// Top level of the PWM code frame receiver: edge timing, frame assembly, result buffer.
// Depends on pcfr_pkg, pcfr_if (pcfr_req_if, pcfr_rsp_if) and pcfr_csr.
`default_nettype none

// Takes one edge word per clock while req ready is high and returns exactly one result word
// per edge word. The pulse length, window compares and bit shift are done in the accepting
// cycle and the result is registered in the output register, or in the skid register while
// the output holds a waiting word (one edge per clock sustained while results are accepted).
// A one-word skid register behind the output keeps the input open for one more edge while
// a result waits; req ready drops only when both are full. A result carries frame_done = 1
// and the decoded fields on the edge that completes a 66-bit frame; on every other edge all
// fields are zero. Write the timing registers only while no edge is in flight.
module pwm_code_frame_receiver_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   pcfr_req_if.sink                                  req_chan,
   pcfr_rsp_if.source                                rsp_chan,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [pcfr_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [31:0]                          pwdata,
   output logic      [31:0]                          prdata,
   output logic                                      pready
);
   import pcfr_pkg::*;

   cfg_type                    cfg;

   logic [31:0]                last_edge_ff;
   logic [4:0]                 preamble_count_ff;
   logic [4:0]                 preamble_count_in;
   logic                       header_seen_ff;
   logic                       header_seen_in;
   logic [BIT_COUNT_WIDTH-1:0] bit_count_ff;
   logic [BIT_COUNT_WIDTH-1:0] bit_count_in;
   logic [FRAME_BITS-1:0]      frame_ff;
   logic [FRAME_BITS-1:0]      frame_shift;
   logic                       store_bit;

   rsp_type                    result_in;
   rsp_type                    out_ff;
   rsp_type                    skid_ff;
   logic                       out_valid_ff;
   logic                       skid_valid_ff;

   logic [31:0]                pulse;
   logic                       fire_in;
   logic                       fire_out;
   logic                       falling;
   logic                       at_target;
   logic                       preamble_ok;
   logic                       header_ok;
   logic                       bit_ok;
   logic                       bit_value;
   logic [4:0]                 count_plus;

   pcfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign fire_in        = req_chan.valid && req_chan.ready;
   assign fire_out       = out_valid_ff && rsp_chan.ready;
   assign req_chan.ready = !skid_valid_ff;

   assign pulse       = req_chan.edge_time_us - last_edge_ff;
   assign falling     = !req_chan.edge_level;
   assign at_target   = preamble_count_ff == cfg.preamble_needed;
   assign count_plus  = preamble_count_ff + 5'd1;
   assign preamble_ok = (pulse > {16'd0, cfg.short_min_us}) &&
                        (pulse < {16'd0, cfg.preamble_max_us});
   assign header_ok   = (pulse > {16'd0, cfg.header_min_us}) &&
                        (pulse < {16'd0, cfg.header_max_us});
   assign bit_ok      = (pulse > {16'd0, cfg.short_min_us}) &&
                        (pulse < {16'd0, cfg.bit_max_us}) &&
                        (bit_count_ff < BIT_COUNT_WIDTH'(FRAME_BITS));
   assign bit_value   = !(pulse > {16'd0, cfg.bit_split_us});
   assign frame_shift = {bit_value, frame_ff[FRAME_BITS-1:1]};

   always_comb begin
      preamble_count_in = preamble_count_ff;
      header_seen_in    = header_seen_ff;
      bit_count_in      = bit_count_ff;
      store_bit         = 1'b0;
      result_in         = '0;
      if (preamble_count_ff < cfg.preamble_needed) begin
         if (falling) begin
            if (preamble_ok) begin
               preamble_count_in = count_plus;
            end else begin
               preamble_count_in = 5'd0;
               header_seen_in    = 1'b0;
            end
         end
      end else if (at_target) begin
         if (!falling && header_ok) begin
            header_seen_in = 1'b1;
            bit_count_in   = '0;
         end else if (header_seen_ff && falling) begin
            if (bit_ok) begin
               store_bit    = 1'b1;
               bit_count_in = bit_count_ff + BIT_COUNT_WIDTH'(1);
               if (bit_count_in == BIT_COUNT_WIDTH'(FRAME_BITS)) begin
                  result_in.frame_done    = 1'b1;
                  result_in.repeat_flag   = frame_shift[65];
                  result_in.battery_low   = frame_shift[64];
                  result_in.buttons       = {frame_shift[60], frame_shift[63],
                                             frame_shift[62], frame_shift[61]};
                  result_in.serial_number = frame_shift[59:32];
                  result_in.hopping_code  = frame_shift[31:0];
                  result_in.raw_code      = frame_shift[63:0];
                  preamble_count_in       = 5'd0;
                  header_seen_in          = 1'b0;
               end
            end else begin
               preamble_count_in = 5'd0;
               header_seen_in    = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff      <= 32'd0;
         preamble_count_ff <= 5'd0;
         header_seen_ff    <= 1'b0;
         bit_count_ff      <= '0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (fire_in) begin
            last_edge_ff      <= req_chan.edge_time_us;
            preamble_count_ff <= preamble_count_in;
            header_seen_ff    <= header_seen_in;
            bit_count_ff      <= bit_count_in;
         end
         if (fire_out || !out_valid_ff) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= fire_in;
            end
         end else if (fire_in) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire_in && store_bit) begin
         frame_ff <= frame_shift;
      end
      if (fire_out || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else begin
            out_ff <= result_in;
         end
      end else if (fire_in) begin
         skid_ff <= result_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.frame_done    = out_ff.frame_done;
   assign rsp_chan.repeat_flag   = out_ff.repeat_flag;
   assign rsp_chan.battery_low   = out_ff.battery_low;
   assign rsp_chan.buttons       = out_ff.buttons;
   assign rsp_chan.serial_number = out_ff.serial_number;
   assign rsp_chan.hopping_code  = out_ff.hopping_code;
   assign rsp_chan.raw_code      = out_ff.raw_code;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held while output register empty");

   a_frame_clears_sync: assert property (@(posedge clock) disable iff (reset)
      fire_in && result_in.frame_done |=> preamble_count_ff == 5'd0 && !header_seen_ff)
      else $error("preamble or header state survived a completed frame");

   a_idle_result_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.frame_done |-> out_ff.raw_code == 64'd0 &&
         out_ff.serial_number == 28'd0 && out_ff.buttons == 4'd0)
      else $error("nonzero fields on a word without a frame");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BIT_COUNT_WIDTH'(FRAME_BITS))
      else $error("bit count beyond frame length");
`endif

endmodule

`default_nettype wire

@@ rtl/pcfr_csr.sv @@
// APB-style register block holding the pulse timing windows and preamble length.
// Depends on pcfr_pkg.
`default_nettype none

module pcfr_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [pcfr_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [31:0]                          pwdata,
   output logic      [31:0]                          prdata,
   output logic                                      pready,
   output pcfr_pkg::cfg_type                         cfg
);
   import pcfr_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_en;

   assign reg_index = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_SHORT_MIN:       cfg_in.short_min_us    = pwdata[15:0];
            REG_PREAMBLE_MAX:    cfg_in.preamble_max_us = pwdata[15:0];
            REG_HEADER_MIN:      cfg_in.header_min_us   = pwdata[15:0];
            REG_HEADER_MAX:      cfg_in.header_max_us   = pwdata[15:0];
            REG_BIT_MAX:         cfg_in.bit_max_us      = pwdata[15:0];
            REG_BIT_SPLIT:       cfg_in.bit_split_us    = pwdata[15:0];
            REG_PREAMBLE_NEEDED: cfg_in.preamble_needed = pwdata[4:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SHORT_MIN:       prdata = {16'd0, cfg_ff.short_min_us};
         REG_PREAMBLE_MAX:    prdata = {16'd0, cfg_ff.preamble_max_us};
         REG_HEADER_MIN:      prdata = {16'd0, cfg_ff.header_min_us};
         REG_HEADER_MAX:      prdata = {16'd0, cfg_ff.header_max_us};
         REG_BIT_MAX:         prdata = {16'd0, cfg_ff.bit_max_us};
         REG_BIT_SPLIT:       prdata = {16'd0, cfg_ff.bit_split_us};
         REG_PREAMBLE_NEEDED: prdata = {27'd0, cfg_ff.preamble_needed};
         default:             prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_min_us    <= 16'd280;
         cfg_ff.preamble_max_us <= 16'd620;
         cfg_ff.header_min_us   <= 16'd2800;
         cfg_ff.header_max_us   <= 16'd6200;
         cfg_ff.bit_max_us      <= 16'd1240;
         cfg_ff.bit_split_us    <= 16'd560;
         cfg_ff.preamble_needed <= 5'd12;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ verif/pcfr_frame_compare.sv @@
// Result checker for the PWM code frame receiver: tracks register writes and edge words,
// predicts every result word and compares it field by field. Depends on pcfr_pkg and pcfr_if.
`default_nettype none

module pcfr_frame_compare (
   input  wire logic                                clock,
   input  wire logic                                reset,
   pcfr_req_if                                      edge_mon,
   pcfr_rsp_if                                      frame_mon,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic                                pready,
   input  wire logic [pcfr_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [31:0]                         pwdata,
   input  wire logic [31:0]                         prdata,
   output int                                       fail_count,
   output int                                       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import pcfr_pkg::*;

   cfg_type           cfg;
   logic [31:0]       last_us;
   logic [4:0]        pre_cnt;
   logic              hdr_seen;
   logic [6:0]        bit_cnt;
   logic [65:0]       rx_bits;
   rsp_type           due_results[$];
   rsp_type           want;
   rsp_type           got;
   int                errors = 0;

   function automatic rsp_type decode_edge(input logic lvl, input logic [31:0] t_us);
      logic [31:0] pulse;
      rsp_type     r;
      pulse   = t_us - last_us;
      last_us = t_us;
      r       = '0;
      if (pre_cnt < cfg.preamble_needed && !lvl) begin
         if (pulse > {16'd0, cfg.short_min_us} && pulse < {16'd0, cfg.preamble_max_us}) begin
            pre_cnt = pre_cnt + 5'd1;
            if (pre_cnt == cfg.preamble_needed) return r;
         end else begin
            pre_cnt  = '0;
            hdr_seen = 1'b0;
            return r;
         end
      end
      if (pre_cnt == cfg.preamble_needed && lvl &&
          pulse > {16'd0, cfg.header_min_us} && pulse < {16'd0, cfg.header_max_us}) begin
         hdr_seen = 1'b1;
         bit_cnt  = '0;
         return r;
      end
      if (pre_cnt == cfg.preamble_needed && hdr_seen && !lvl) begin
         if (pulse > {16'd0, cfg.short_min_us} && pulse < {16'd0, cfg.bit_max_us} &&
             bit_cnt < 7'(FRAME_BITS)) begin
            rx_bits[bit_cnt] = (pulse <= {16'd0, cfg.bit_split_us});
            bit_cnt          = bit_cnt + 7'd1;
            if (bit_cnt == 7'(FRAME_BITS)) begin
               r.frame_done    = 1'b1;
               r.repeat_flag   = rx_bits[65];
               r.battery_low   = rx_bits[64];
               r.buttons       = {rx_bits[60], rx_bits[63], rx_bits[62], rx_bits[61]};
               r.serial_number = rx_bits[59:32];
               r.hopping_code  = rx_bits[31:0];
               r.raw_code      = rx_bits[63:0];
               pre_cnt         = '0;
               hdr_seen        = 1'b0;
            end
         end else begin
            pre_cnt  = '0;
            hdr_seen = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] reg_value(input reg_index_type idx);
      case (idx)
         REG_SHORT_MIN:       return {16'd0, cfg.short_min_us};
         REG_PREAMBLE_MAX:    return {16'd0, cfg.preamble_max_us};
         REG_HEADER_MIN:      return {16'd0, cfg.header_min_us};
         REG_HEADER_MAX:      return {16'd0, cfg.header_max_us};
         REG_BIT_MAX:         return {16'd0, cfg.bit_max_us};
         REG_BIT_SPLIT:       return {16'd0, cfg.bit_split_us};
         REG_PREAMBLE_NEEDED: return {27'd0, cfg.preamble_needed};
         default:             return 32'd0;
      endcase
   endfunction

   function automatic void diff_field(input string fname, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.short_min_us    = 16'd280;
         cfg.preamble_max_us = 16'd620;
         cfg.header_min_us   = 16'd2800;
         cfg.header_max_us   = 16'd6200;
         cfg.bit_max_us      = 16'd1240;
         cfg.bit_split_us    = 16'd560;
         cfg.preamble_needed = 5'd12;
         last_us             = '0;
         pre_cnt             = '0;
         hdr_seen            = 1'b0;
         bit_cnt             = '0;
         rx_bits             = '0;
         due_results.delete();
      end else begin
         if (psel && penable && !pwrite && pready)
            diff_field("prdata", {32'd0, reg_value(reg_index_type'(paddr[4:2]))},
                       {32'd0, prdata});
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[4:2]))
               REG_SHORT_MIN:       cfg.short_min_us    = pwdata[15:0];
               REG_PREAMBLE_MAX:    cfg.preamble_max_us = pwdata[15:0];
               REG_HEADER_MIN:      cfg.header_min_us   = pwdata[15:0];
               REG_HEADER_MAX:      cfg.header_max_us   = pwdata[15:0];
               REG_BIT_MAX:         cfg.bit_max_us      = pwdata[15:0];
               REG_BIT_SPLIT:       cfg.bit_split_us    = pwdata[15:0];
               REG_PREAMBLE_NEEDED: cfg.preamble_needed = pwdata[4:0];
               default: ;
            endcase
         end
         if (edge_mon.valid && edge_mon.ready)
            due_results.push_back(decode_edge(edge_mon.edge_level, edge_mon.edge_time_us));
         if (frame_mon.valid && frame_mon.ready) begin
            got.frame_done    = frame_mon.frame_done;
            got.repeat_flag   = frame_mon.repeat_flag;
            got.battery_low   = frame_mon.battery_low;
            got.buttons       = frame_mon.buttons;
            got.serial_number = frame_mon.serial_number;
            got.hopping_code  = frame_mon.hopping_code;
            got.raw_code      = frame_mon.raw_code;
            if (due_results.size() == 0) begin
               errors++;
               $display("%0t: result word with no edge pending, expected none, actual %0h",
                        $time, got);
            end else begin
               want = due_results.pop_front();
               diff_field("frame_done", 64'(want.frame_done), 64'(got.frame_done));
               diff_field("repeat_flag", 64'(want.repeat_flag), 64'(got.repeat_flag));
               diff_field("battery_low", 64'(want.battery_low), 64'(got.battery_low));
               diff_field("buttons", 64'(want.buttons), 64'(got.buttons));
               diff_field("serial_number", 64'(want.serial_number),
                          64'(got.serial_number));
               diff_field("hopping_code", 64'(want.hopping_code), 64'(got.hopping_code));
               diff_field("raw_code", want.raw_code, got.raw_code);
            end
         end
      end
      fail_count  <= errors;
      outstanding <= due_results.size();
   end

endmodule

`default_nettype wire

@@ verif/pwm_code_frame_receiver_core_tb.sv @@
// Testbench top for the PWM code frame receiver: clock, reset, register writes, edge words
// and result stalls, plus the verdict. Depends on pcfr_pkg, pcfr_if and pcfr_frame_compare.
`default_nettype none

module pwm_code_frame_receiver_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcfr_pkg::*;

   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_ADDR = {3'd7, 2'b00};

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;
   int                        fail_count;
   int                        outstanding;

   cfg_type                   win;
   logic [31:0]               now_us;
   logic                      steady;
   int                        items_sent;
   int                        frames_sent;
   int                        stall_left;
   int                        stall_draw;

   pcfr_req_if edge_chan();
   pcfr_rsp_if frame_chan();

   pwm_code_frame_receiver_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (edge_chan),
      .rsp_chan (frame_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   pcfr_frame_compare compare_u (
      .clock       (clock),
      .reset       (reset),
      .edge_mon    (edge_chan),
      .frame_mon   (frame_chan),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         frame_chan.ready <= 1'b0;
         stall_left       <= 0;
      end else if (frame_chan.valid && frame_chan.ready) begin
         stall_draw = steady ? 0 : $urandom_range(0, 7);
         stall_left       <= stall_draw;
         frame_chan.ready <= (stall_draw == 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left       <= 0;
         frame_chan.ready <= 1'b1;
      end
   end

   task automatic apb_write(input logic [CSR_ADDR_WIDTH-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apb_read(input logic [CSR_ADDR_WIDTH-1:0] addr);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_cfg(input cfg_type c);
      int r;
      apb_write({REG_SHORT_MIN, 2'b00},       {16'($urandom), c.short_min_us});
      apb_write({REG_PREAMBLE_MAX, 2'b00},    {16'($urandom), c.preamble_max_us});
      apb_write({REG_HEADER_MIN, 2'b00},      {16'($urandom), c.header_min_us});
      apb_write({REG_HEADER_MAX, 2'b00},      {16'($urandom), c.header_max_us});
      apb_write({REG_BIT_MAX, 2'b00},         {16'($urandom), c.bit_max_us});
      apb_write({REG_BIT_SPLIT, 2'b00},       {16'($urandom), c.bit_split_us});
      apb_write({REG_PREAMBLE_NEEDED, 2'b00}, {27'($urandom), c.preamble_needed});
      win = c;
      for (r = 0; r < 8; r++) apb_read(CSR_ADDR_WIDTH'(r * 4));
   endtask

   function automatic cfg_type plausible_cfg(input logic [4:0] needed);
      cfg_type c;
      c.short_min_us    = 16'($urandom_range(0, 600));
      c.preamble_max_us = c.short_min_us + 16'($urandom_range(2, 900));
      c.bit_split_us    = c.short_min_us + 16'($urandom_range(0, 700));
      c.bit_max_us      = c.bit_split_us + 16'($urandom_range(2, 900));
      c.header_min_us   = 16'($urandom_range(0, 9000));
      c.header_max_us   = c.header_min_us + 16'($urandom_range(2, 9000));
      c.preamble_needed = needed;
      return c;
   endfunction

   function automatic logic [31:0] pick_in(input logic [15:0] lo, input logic [15:0] hi);
      if ({16'd0, hi} > {16'd0, lo} + 32'd1)
         return $urandom_range({16'd0, lo} + 32'd1, {16'd0, hi} - 32'd1);
      return {16'd0, lo};
   endfunction

   function automatic logic [31:0] bit_pulse(input logic b);
      logic [15:0] zero_lo;
      logic [15:0] one_hi;
      zero_lo = (win.bit_split_us > win.short_min_us) ? win.bit_split_us : win.short_min_us;
      one_hi  = ({16'd0, win.bit_split_us} + 32'd1 < {16'd0, win.bit_max_us}) ?
                win.bit_split_us + 16'd1 : win.bit_max_us;
      if (!b && {16'd0, win.bit_max_us} > {16'd0, zero_lo} + 32'd1)
         return pick_in(zero_lo, win.bit_max_us);
      if (b && {16'd0, one_hi} > {16'd0, win.short_min_us} + 32'd1)
         return pick_in(win.short_min_us, one_hi);
      return pick_in(win.short_min_us, win.bit_max_us);
   endfunction

   function automatic logic [31:0] low_gap();
      logic [31:0] g;
      g = $urandom_range(0, 1500);
      if (g > {16'd0, win.header_min_us} && g < {16'd0, win.header_max_us})
         g = {16'd0, win.header_min_us};
      return g;
   endfunction

   task automatic send_edge(input logic lvl, input logic [31:0] delta);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         edge_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      now_us = now_us + delta;
      edge_chan.valid        <= 1'b1;
      edge_chan.edge_level   <= lvl;
      edge_chan.edge_time_us <= now_us;
      @(posedge clock);
      while (!edge_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      edge_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_frame();
      int fault_kind;
      int fault_at;
      int k;
      fault_kind = $urandom_range(0, 9);
      fault_at   = $urandom_range(0, FRAME_BITS - 1);
      for (k = 0; k < int'(win.preamble_needed); k++) begin
         send_edge(1'b1, $urandom_range(1, 3000));
         send_edge(1'b0, pick_in(win.short_min_us, win.preamble_max_us));
      end
      send_edge(1'b1, pick_in(win.header_min_us, win.header_max_us));
      for (k = 0; k < FRAME_BITS; k++) begin
         if (k == fault_at && fault_kind == 0) begin
            send_edge(1'b0, $urandom_range(0, 1) ? {16'd0, win.short_min_us} :
                                                   {16'd0, win.bit_max_us});
            return;
         end
         send_edge(1'b0, bit_pulse(1'($urandom_range(0, 1))));
         if (k < FRAME_BITS - 1) begin
            if (k == fault_at && fault_kind == 1) begin
               send_edge(1'b1, pick_in(win.header_min_us, win.header_max_us));
               fault_kind = 2;
               k = -1;
            end else begin
               send_edge(1'b1, low_gap());
            end
         end
      end
      frames_sent++;
   endtask

   task automatic send_noise();
      int n;
      logic [31:0] d;
      n = $urandom_range(1, 8);
      repeat (n) begin
         case ($urandom_range(0, 13))
            0:       d = {16'd0, win.short_min_us};
            1:       d = {16'd0, win.short_min_us} + 32'd1;
            2:       d = {16'd0, win.preamble_max_us} - 32'd1;
            3:       d = {16'd0, win.preamble_max_us};
            4:       d = {16'd0, win.header_min_us};
            5:       d = {16'd0, win.header_min_us} + 32'd1;
            6:       d = {16'd0, win.header_max_us} - 32'd1;
            7:       d = {16'd0, win.header_max_us};
            8:       d = {16'd0, win.bit_max_us} - 32'd1;
            9:       d = {16'd0, win.bit_max_us};
            10:      d = {16'd0, win.bit_split_us};
            11:      d = {16'd0, win.bit_split_us} + 32'd1;
            12:      d = $urandom_range(0, 7000);
            default: d = $urandom;
         endcase
         if ($urandom_range(0, 7) == 0) now_us = $urandom;
         send_edge(1'($urandom_range(0, 1)), d);
      end
   endtask

   initial begin
      cfg_type c;
      int      ph;
      int      quota;
      int      want_frames;
      int      item0;
      int      frame0;
      logic    framable;

      reset                  = 1'b1;
      psel                   = 1'b0;
      penable                = 1'b0;
      pwrite                 = 1'b0;
      paddr                  = '0;
      pwdata                 = '0;
      edge_chan.valid        = 1'b0;
      edge_chan.edge_level   = 1'b0;
      edge_chan.edge_time_us = '0;
      frame_chan.ready       = 1'b0;
      steady                 = 1'b0;
      now_us                 = '0;
      items_sent             = 0;
      frames_sent            = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      win.short_min_us    = 16'd280;
      win.preamble_max_us = 16'd620;
      win.header_min_us   = 16'd2800;
      win.header_max_us   = 16'd6200;
      win.bit_max_us      = 16'd1240;
      win.bit_split_us    = 16'd560;
      win.preamble_needed = 5'd12;

      send_edge(1'b0, 32'd0);
      now_us = 32'hFFFF_FF00;
      send_edge(1'b1, 32'd0);
      send_edge(1'b0, 32'd280);
      send_edge(1'b0, 32'd281);
      send_edge(1'b1, 32'd50);
      send_edge(1'b0, 32'd619);
      send_edge(1'b0, 32'd620);
      now_us = 32'hFFFF_FFFF;
      send_edge(1'b1, 32'd0);
      send_edge(1'b0, 32'd1);
      now_us = 32'hFFFF_FFFF;
      send_edge(1'b0, 32'd0);
      send_edge(1'b1, 32'd6199);
      send_edge(1'b1, 32'd2801);
      drain();

      for (ph = 0; ph < 8; ph++) begin
         c           = win;
         quota       = 20;
         want_frames = 0;
         case (ph)
            0: begin
               c.short_min_us    = 16'd280;
               c.preamble_max_us = 16'd620;
               c.header_min_us   = 16'd2800;
               c.header_max_us   = 16'd6200;
               c.bit_max_us      = 16'd1240;
               c.bit_split_us    = 16'd560;
               c.preamble_needed = 5'd12;
               want_frames       = 1;
            end
            1: begin
               c = plausible_cfg(5'($urandom_range(1, 4)));
               want_frames = 1;
            end
            2: begin
               c = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31};
               quota = 20;
            end
            3: begin
               c = '{16'd0, 16'd2, 16'hFFFD, 16'hFFFF, 16'hFFFF, 16'd0, 5'd1};
               quota = 20;
            end
            4: begin
               c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31};
            end
            5: begin
               c = '0;
            end
            6: c = plausible_cfg(5'd0);
            default: begin
               c = plausible_cfg(5'($urandom_range(1, 31)));
               quota = 30;
            end
         endcase
         write_cfg(c);
         if (ph == 1) apb_write(SPARE_ADDR, $urandom);
         framable = ({16'd0, win.preamble_max_us} > {16'd0, win.short_min_us} + 32'd1 ||
                     win.preamble_needed == 5'd0) &&
                    {16'd0, win.header_max_us} > {16'd0, win.header_min_us} + 32'd1 &&
                    {16'd0, win.bit_max_us} > {16'd0, win.short_min_us} + 32'd1;
         item0  = items_sent;
         frame0 = frames_sent;
         while (items_sent - item0 < quota || (framable && frames_sent - frame0 < want_frames))
         begin
            steady = ($urandom_range(0, 3) == 0);
            if (framable && frames_sent - frame0 < want_frames && $urandom_range(0, 9) < 7)
               send_frame();
            else
               send_noise();
            if ($urandom_range(0, 15) == 0) drain();
         end
         steady = 1'b0;
         drain();
      end

      drain();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/pcfr_pkg.sv
rtl/pcfr_if.sv
rtl/pcfr_csr.sv
rtl/pwm_code_frame_receiver_core.sv
verif/pcfr_frame_compare.sv
verif/pwm_code_frame_receiver_core_tb.sv
